// ===== sv/stcs_pkg.sv =====
package stcs_pkg;

	localparam int CNT_W     = 9;
	localparam int NUM_CNT   = 12;
	localparam int CIDX_W    = $clog2(NUM_CNT);
	localparam int ROW_W     = CNT_W * NUM_CNT;
	localparam int FREQ_W    = 16;
	localparam int NUM_FREQ  = 4;
	localparam int SUM_W     = CNT_W + 1;
	localparam int PSUM_W    = 4 * SUM_W + 3;
	localparam int COEF_W    = 18;
	localparam int K_W       = 2 * COEF_W;
	localparam int MUL_W     = 32;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int ACC_W     = K_W + PSUM_W + 3;
	localparam int FRAC_SH   = 24;
	localparam int SCORE_W   = 64;
	localparam int SITE_W    = 10;
	localparam int BASE_W    = 4;
	localparam int GRP_W     = 3;
	localparam int CFG_IDX_W = 2;

	localparam int NUM_SITES_DEF = 1024;
	localparam int MAX_TAXA_DEF  = 256;

	localparam logic [CFG_IDX_W-1:0] REG_FREQ_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_C = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_G = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FREQ_T = 2'd3;

	localparam logic [FREQ_W-1:0] FREQ_A_RST = 16'd19005;
	localparam logic [FREQ_W-1:0] FREQ_C_RST = 16'd13763;
	localparam logic [FREQ_W-1:0] FREQ_G_RST = 16'd13763;
	localparam logic [FREQ_W-1:0] FREQ_T_RST = 16'd19005;

	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_SCORE  = 1'b1;

	typedef logic [NUM_CNT-1:0][CNT_W-1:0]   cnt_row_t;
	typedef logic [NUM_FREQ-1:0][FREQ_W-1:0] freq_set_t;
	typedef logic [2:0]                      vsel_t;

	localparam vsel_t VS_A = 3'd0;
	localparam vsel_t VS_C = 3'd1;
	localparam vsel_t VS_G = 3'd2;
	localparam vsel_t VS_T = 3'd3;
	localparam vsel_t VS_R = 3'd4;
	localparam vsel_t VS_Y = 3'd5;

	typedef struct packed {
		vsel_t      xs;
		vsel_t      ys;
		logic [1:0] bkt;
	} pair_t;

	typedef struct packed {
		logic busy;
		logic done;
	} eng_stat_t;

	// pair-sum list: bucket 0 is +K1, 1 is -K2, 2 is -K3, 3 is +K4
	function automatic pair_t pair_sel(input logic [3:0] idx);
		pair_t p;
		unique case (idx)
			4'd0:    p = '{xs: VS_R, ys: VS_Y, bkt: 2'd0};
			4'd1:    p = '{xs: VS_A, ys: VS_Y, bkt: 2'd1};
			4'd2:    p = '{xs: VS_G, ys: VS_Y, bkt: 2'd1};
			4'd3:    p = '{xs: VS_R, ys: VS_C, bkt: 2'd2};
			4'd4:    p = '{xs: VS_R, ys: VS_T, bkt: 2'd2};
			4'd5:    p = '{xs: VS_A, ys: VS_C, bkt: 2'd3};
			4'd6:    p = '{xs: VS_A, ys: VS_T, bkt: 2'd3};
			4'd7:    p = '{xs: VS_G, ys: VS_C, bkt: 2'd3};
			4'd8:    p = '{xs: VS_G, ys: VS_T, bkt: 2'd3};
			default: p = '{xs: VS_A, ys: VS_A, bkt: 2'd0};
		endcase
		return p;
	endfunction

endpackage

// ===== sv/stcs_ram.sv =====
module stcs_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/stcs_mul.sv =====
module stcs_mul import stcs_pkg::*; (
	input  logic              clk,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

// ===== sv/stcs_score.sv =====
module stcs_score import stcs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  cnt_row_t           counts,
	input  freq_set_t          freqs,
	output eng_stat_t          stat,
	output logic [SCORE_W-1:0] score
);

	localparam logic [2:0] E_IDLE  = 3'd0;
	localparam logic [2:0] E_COEF  = 3'd1;
	localparam logic [2:0] E_PAIR  = 3'd2;
	localparam logic [2:0] E_KMUL  = 3'd3;
	localparam logic [2:0] E_DRAIN = 3'd4;
	localparam logic [2:0] E_RND   = 3'd5;

	localparam logic [3:0] COEF_LAST = 4'd10;
	localparam logic [3:0] PAIR_LAST = 4'd8;
	localparam logic [2:0] TERM_LAST = 3'd5;
	localparam logic [1:0] STEP_LAST = 2'd2;

	logic [2:0] st_q;
	logic [3:0] step_q;
	logic [3:0] pi_q;
	logic [2:0] tj_q;
	logic [1:0] sk_q;
	logic [1:0] kb_q;
	logic [1:0] kp_q;
	logic       pend_pair_q;
	logic       pend_k_q;
	logic [1:0] pend_bkt_q;
	logic [1:0] pend_sh_q;
	logic       pend_neg_q;

	cnt_row_t                        cnt_q;
	logic [2*FREQ_W-1:0]             tmp_q;
	logic [COEF_W-1:0]               r2_q, y2_q, rr_q, yy_q;
	logic [3:0][K_W-1:0]             k_q;
	logic [3:0][PSUM_W-1:0]          s_q;
	logic signed [ACC_W-1:0]         acc_q;

	logic [MUL_W-1:0]  opa, opb;
	logic [PROD_W-1:0] prod;
	logic [FREQ_W:0]   r_sum, y_sum;
	pair_t             pr;
	logic [1:0]        ti, ti1, ti2;
	logic              tsw;
	vsel_t             usel, vsel;
	logic [SUM_W-1:0]  u_v, v_v, w_v;
	logic [K_W-1:0]    kk;
	logic [PSUM_W-1:0] ss;
	logic [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0] rnd_v, sh_v;

	function automatic logic [SUM_W-1:0] vget(input cnt_row_t c, input vsel_t s,
			input logic [1:0] g);
		logic [SUM_W-1:0] av, cv, gv, tv;
		av = SUM_W'(c[{g, 2'd0}]);
		cv = SUM_W'(c[{g, 2'd1}]);
		gv = SUM_W'(c[{g, 2'd2}]);
		tv = SUM_W'(c[{g, 2'd3}]);
		unique case (s)
			VS_A:    return av;
			VS_C:    return cv;
			VS_G:    return gv;
			VS_T:    return tv;
			VS_R:    return av + gv;
			VS_Y:    return cv + tv;
			default: return '0;
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] rnd16(input logic [2*FREQ_W+2:0] v);
		logic [2*FREQ_W+2:0] t;
		t = (v + (2*FREQ_W+3)'(32768)) >> FREQ_W;
		return t[COEF_W-1:0];
	endfunction

	stcs_mul u_mul (
		.clk (clk),
		.a   (opa),
		.b   (opb),
		.p   (prod)
	);

	assign r_sum = {1'b0, freqs[0]} + {1'b0, freqs[2]};
	assign y_sum = {1'b0, freqs[1]} + {1'b0, freqs[3]};

	always_comb begin
		pr   = pair_sel(pi_q);
		tsw  = (tj_q > 3'd2);
		ti   = tsw ? 2'(tj_q - 3'd3) : tj_q[1:0];
		ti1  = (ti == 2'd2) ? 2'd0 : ti + 2'd1;
		ti2  = (ti == 2'd0) ? 2'd2 : ti - 2'd1;
		usel = tsw ? pr.ys : pr.xs;
		vsel = tsw ? pr.xs : pr.ys;
		u_v  = vget(cnt_q, usel, ti);
		v_v  = vget(cnt_q, vsel, ti1);
		w_v  = vget(cnt_q, vsel, ti2);
		kk   = k_q[kb_q];
		ss   = s_q[kb_q];
	end

	always_comb begin
		opa = '0;
		opb = '0;
		unique case (st_q)
			E_COEF: begin
				unique case (step_q)
					4'd0:    begin opa = MUL_W'(freqs[0]); opb = MUL_W'(freqs[0]); end
					4'd1:    begin opa = MUL_W'(freqs[2]); opb = MUL_W'(freqs[2]); end
					4'd2:    begin opa = MUL_W'(freqs[1]); opb = MUL_W'(freqs[1]); end
					4'd3:    begin opa = MUL_W'(freqs[3]); opb = MUL_W'(freqs[3]); end
					4'd4:    begin opa = MUL_W'(r_sum); opb = MUL_W'(r_sum); end
					4'd5:    begin opa = MUL_W'(y_sum); opb = MUL_W'(y_sum); end
					4'd6:    begin opa = MUL_W'(r2_q); opb = MUL_W'(y2_q); end
					4'd7:    begin opa = MUL_W'(rr_q); opb = MUL_W'(y2_q); end
					4'd8:    begin opa = MUL_W'(r2_q); opb = MUL_W'(yy_q); end
					4'd9:    begin opa = MUL_W'(rr_q); opb = MUL_W'(yy_q); end
					default: begin opa = '0; opb = '0; end
				endcase
			end
			E_PAIR: begin
				unique case (sk_q)
					2'd0:    begin opa = MUL_W'(u_v); opb = MUL_W'(u_v - SUM_W'(1)); end
					2'd1:    begin opa = prod[MUL_W-1:0]; opb = MUL_W'(v_v); end
					default: begin opa = prod[MUL_W-1:0]; opb = MUL_W'(w_v); end
				endcase
			end
			E_KMUL: begin
				opa = kp_q[1] ? MUL_W'(kk[K_W-1:MUL_W]) : kk[MUL_W-1:0];
				opb = kp_q[0] ? MUL_W'(ss[PSUM_W-1:MUL_W]) : ss[MUL_W-1:0];
			end
			default: begin opa = '0; opb = '0; end
		endcase
	end

	assign addend = ACC_W'(prod) << {pend_sh_q, 5'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= E_IDLE;
			step_q      <= '0;
			pi_q        <= '0;
			tj_q        <= '0;
			sk_q        <= '0;
			kb_q        <= '0;
			kp_q        <= '0;
			pend_pair_q <= 1'b0;
			pend_k_q    <= 1'b0;
			pend_bkt_q  <= '0;
			pend_sh_q   <= '0;
			pend_neg_q  <= 1'b0;
		end else begin
			pend_pair_q <= 1'b0;
			pend_k_q    <= 1'b0;
			unique case (st_q)
				E_IDLE: begin
					if (start) begin
						st_q   <= E_COEF;
						step_q <= '0;
						pi_q   <= '0;
						tj_q   <= '0;
						sk_q   <= '0;
						kb_q   <= '0;
						kp_q   <= '0;
					end
				end
				E_COEF: begin
					step_q <= step_q + 4'd1;
					if (step_q == COEF_LAST)
						st_q <= E_PAIR;
				end
				E_PAIR: begin
					pend_pair_q <= (sk_q == STEP_LAST);
					pend_bkt_q  <= pr.bkt;
					if (sk_q == STEP_LAST) begin
						sk_q <= '0;
						if (tj_q == TERM_LAST) begin
							tj_q <= '0;
							pi_q <= pi_q + 4'd1;
							if (pi_q == PAIR_LAST)
								st_q <= E_KMUL;
						end else begin
							tj_q <= tj_q + 3'd1;
						end
					end else begin
						sk_q <= sk_q + 2'd1;
					end
				end
				E_KMUL: begin
					pend_k_q   <= 1'b1;
					pend_sh_q  <= 2'(kp_q[0]) + 2'(kp_q[1]);
					pend_neg_q <= (kb_q == 2'd1) || (kb_q == 2'd2);
					kp_q       <= kp_q + 2'd1;
					if (kp_q == 2'd3) begin
						kb_q <= kb_q + 2'd1;
						if (kb_q == 2'd3)
							st_q <= E_DRAIN;
					end
				end
				E_DRAIN: st_q <= E_RND;
				E_RND:   st_q <= E_IDLE;
				default: st_q <= E_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == E_IDLE && start) begin
			cnt_q <= counts;
			s_q   <= '0;
			acc_q <= '0;
		end else begin
			if (pend_pair_q)
				s_q[pend_bkt_q] <= s_q[pend_bkt_q] + PSUM_W'(prod);
			if (pend_k_q)
				acc_q <= pend_neg_q ? acc_q - addend : acc_q + addend;
		end
		if (st_q == E_COEF) begin
			unique case (step_q)
				4'd1:    tmp_q <= prod[2*FREQ_W-1:0];
				4'd2:    r2_q <= rnd16((2*FREQ_W+3)'(tmp_q) + (2*FREQ_W+3)'(prod[2*FREQ_W-1:0]));
				4'd3:    tmp_q <= prod[2*FREQ_W-1:0];
				4'd4:    y2_q <= rnd16((2*FREQ_W+3)'(tmp_q) + (2*FREQ_W+3)'(prod[2*FREQ_W-1:0]));
				4'd5:    rr_q <= rnd16(prod[2*FREQ_W+2:0]);
				4'd6:    yy_q <= rnd16(prod[2*FREQ_W+2:0]);
				4'd7:    k_q[0] <= prod[K_W-1:0];
				4'd8:    k_q[1] <= prod[K_W-1:0];
				4'd9:    k_q[2] <= prod[K_W-1:0];
				4'd10:   k_q[3] <= prod[K_W-1:0];
				default: ;
			endcase
		end
	end

	assign rnd_v = acc_q + (ACC_W'(1) << (FRAC_SH - 1));
	assign sh_v  = rnd_v >>> FRAC_SH;
	assign score = SCORE_W'(sh_v);

	assign stat.busy = (st_q != E_IDLE);
	assign stat.done = (st_q == E_RND);

endmodule

// ===== sv/site_tripartition_count_score_unit.sv =====
// Per-site store of twelve taxon counters (three groups by four bases) with a
// fixed-point score. After reset the store is cleared one site per cycle,
// and no item is taken meanwhile. An update item does one read-modify-write
// of the site's counter row in the RAM, or none when it is ignored, and gives
// no result. A score item holds the input off while the 10 coefficient
// products, the 162 pair-product steps and the 16 partial products of the
// weighting all run through one shared 32x32 multiplier under a small
// sequencer, and its result is then registered. A stalled result holds the
// input off until it leaves. Results leave through an output register; score
// carries 8 fractional bits.
module site_tripartition_count_score_unit import stcs_pkg::*; #(
	parameter int NUM_SITES = NUM_SITES_DEF,
	parameter int MAX_TAXA  = MAX_TAXA_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [SITE_W-1:0]           site,
	input  logic [BASE_W-1:0]           base,
	input  logic signed [GRP_W-1:0]     from_group,
	input  logic signed [GRP_W-1:0]     to_group,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [SCORE_W-1:0]   score,
	output logic [SITE_W-1:0]           score_site,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [FREQ_W-1:0]           cfg_data
);

	localparam int AW = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;

	localparam logic [2:0] T_CLEAR  = 3'd0;
	localparam logic [2:0] T_IDLE   = 3'd1;
	localparam logic [2:0] T_UPD    = 3'd2;
	localparam logic [2:0] T_SC_RD  = 3'd3;
	localparam logic [2:0] T_SC_RUN = 3'd4;
	localparam logic [2:0] T_HOLD   = 3'd5;

	logic [2:0]              state_q;
	logic [AW-1:0]           clr_q;
	freq_set_t               freq_q;
	logic [SITE_W-1:0]       site_q;
	logic [1:0]              base_q;
	logic signed [GRP_W-1:0] from_q, to_q;
	logic                    store_q;
	logic                    out_valid_q;
	logic [SCORE_W-1:0]      score_q;
	logic [SITE_W-1:0]       score_site_q;

	logic                    accept, in_store, out_free, load_out;
	logic                    ram_we, ram_re;
	logic [AW-1:0]           ram_waddr;
	logic [ROW_W-1:0]        ram_wdata, ram_rdata;
	cnt_row_t                row, row_dec, row_inc, eng_counts;
	logic [CIDX_W-1:0]       fidx, tidx;
	logic                    from_ok, to_ok, eng_start;
	eng_stat_t               eng_stat;
	logic [SCORE_W-1:0]      eng_score;

	assign in_stall = (state_q != T_IDLE);
	assign accept   = in_valid && !in_stall;
	assign in_store = (32'(site) < NUM_SITES);
	assign out_free = !out_valid_q || !out_stall;
	assign load_out = eng_stat.done && (state_q == T_SC_RUN) && out_free
		|| (state_q == T_HOLD) && out_free;
	assign cfg_ready = 1'b1;

	assign ram_re = accept && in_store;

	always_comb begin
		row     = cnt_row_t'(ram_rdata);
		from_ok = !from_q[GRP_W-1] && (from_q[1:0] != 2'd3);
		to_ok   = !to_q[GRP_W-1] && (to_q[1:0] != 2'd3);
		fidx    = {from_q[1:0], base_q};
		tidx    = {to_q[1:0], base_q};
		row_dec = row;
		if (from_ok && row[fidx] != '0)
			row_dec[fidx] = row[fidx] - CNT_W'(1);
		row_inc = row_dec;
		if (to_ok && row_dec[tidx] < CNT_W'(MAX_TAXA))
			row_inc[tidx] = row_dec[tidx] + CNT_W'(1);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = AW'(site_q);
		ram_wdata = ROW_W'(row_inc);
		if (state_q == T_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == T_UPD) begin
			ram_we = 1'b1;
		end
	end

	assign eng_start  = (state_q == T_SC_RD);
	assign eng_counts = store_q ? row : '0;

	stcs_ram #(
		.W     (ROW_W),
		.DEPTH (NUM_SITES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (AW'(site)),
		.rdata (ram_rdata)
	);

	stcs_score u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (eng_start),
		.counts (eng_counts),
		.freqs  (freq_q),
		.stat   (eng_stat),
		.score  (eng_score)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			freq_q      <= {FREQ_T_RST, FREQ_G_RST, FREQ_C_RST, FREQ_A_RST};
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_FREQ_A: freq_q[0] <= cfg_data;
					REG_FREQ_C: freq_q[1] <= cfg_data;
					REG_FREQ_G: freq_q[2] <= cfg_data;
					REG_FREQ_T: freq_q[3] <= cfg_data;
					default:    ;
				endcase
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				T_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NUM_SITES - 1))
						state_q <= T_IDLE;
				end
				T_IDLE: begin
					if (accept) begin
						if (func == FUNC_SCORE)
							state_q <= T_SC_RD;
						else if (in_store && base < BASE_W'(4))
							state_q <= T_UPD;
					end
				end
				T_UPD:   state_q <= T_IDLE;
				T_SC_RD: state_q <= T_SC_RUN;
				T_SC_RUN: begin
					if (eng_stat.done)
						state_q <= out_free ? T_IDLE : T_HOLD;
				end
				T_HOLD: begin
					if (out_free)
						state_q <= T_IDLE;
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			site_q  <= site;
			base_q  <= base[1:0];
			from_q  <= from_group;
			to_q    <= to_group;
			store_q <= in_store;
		end
		if (load_out) begin
			score_q      <= eng_score;
			score_site_q <= site_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign score      = score_q;
	assign score_site = score_site_q;

	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_CLEAR) |-> in_stall)
		else $error("item taken during clearing pass");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		eng_start |-> !eng_stat.busy)
		else $error("score engine started while busy");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == T_SC_RUN || state_q == T_HOLD))
		else $error("result raised outside a score transfer");

endmodule

// ===== sim/site_tripartition_count_score_unit_tb.sv =====
module site_tripartition_count_score_unit_tb;
	import stcs_pkg::*;

	typedef longint trio_t [3];

	typedef struct {
		logic                     fn;
		logic [SITE_W-1:0]        st;
		logic [BASE_W-1:0]        bs;
		logic signed [GRP_W-1:0]  fg;
		logic signed [GRP_W-1:0]  tg;
		bit                       typed;
		logic signed [SCORE_W-1:0] sc;
	} stim_t;

	typedef struct {
		logic signed [SCORE_W-1:0] sc;
		logic [SITE_W-1:0]         st;
	} score_exp_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic                      func;
	logic [SITE_W-1:0]         site;
	logic [BASE_W-1:0]         base;
	logic signed [GRP_W-1:0]   from_group;
	logic signed [GRP_W-1:0]   to_group;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [SCORE_W-1:0] score;
	logic [SITE_W-1:0]         score_site;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [FREQ_W-1:0]         cfg_data;

	int           site_counts [NUM_SITES_DEF*NUM_CNT];
	longint       freq_q16 [NUM_FREQ];
	score_exp_t   pending_scores [$];
	int           errs;
	int           n_updates;
	int           n_scores;
	int           n_checked;
	int           idle_cycles;
	bit           no_idle;
	bit           hold_long;
	int           hot_sites [8];

	site_tripartition_count_score_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .site(site), .base(base),
		.from_group(from_group), .to_group(to_group),
		.out_valid(out_valid), .out_stall(out_stall),
		.score(score), .score_site(score_site),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint pair_sum(trio_t x, trio_t y);
		return x[0]*(x[0]-1)*y[1]*y[2] + x[1]*(x[1]-1)*y[2]*y[0]
			+ x[2]*(x[2]-1)*y[0]*y[1] + y[0]*(y[0]-1)*x[1]*x[2]
			+ y[1]*(y[1]-1)*x[2]*x[0] + y[2]*(y[2]-1)*x[0]*x[1];
	endfunction

	function automatic logic signed [SCORE_W-1:0] site_score(int s);
		trio_t ca, cc, cg, ct, cr, cy;
		longint a, c, g, t, r2, y2, rr, yy;
		logic signed [127:0] acc, sh;
		a = freq_q16[REG_FREQ_A];
		c = freq_q16[REG_FREQ_C];
		g = freq_q16[REG_FREQ_G];
		t = freq_q16[REG_FREQ_T];
		r2 = (a*a + g*g + 32768) >> 16;
		y2 = (c*c + t*t + 32768) >> 16;
		rr = ((a+g)*(a+g) + 32768) >> 16;
		yy = ((c+t)*(c+t) + 32768) >> 16;
		for (int i = 0; i < 3; i++) begin
			ca[i] = site_counts[s*NUM_CNT + i*4 + 0];
			cc[i] = site_counts[s*NUM_CNT + i*4 + 1];
			cg[i] = site_counts[s*NUM_CNT + i*4 + 2];
			ct[i] = site_counts[s*NUM_CNT + i*4 + 3];
			cr[i] = ca[i] + cg[i];
			cy[i] = cc[i] + ct[i];
		end
		acc = 128'(r2*y2) * 128'(pair_sum(cr, cy));
		acc = acc - 128'(rr*y2) * 128'(pair_sum(ca, cy) + pair_sum(cg, cy));
		acc = acc - 128'(r2*yy) * 128'(pair_sum(cr, cc) + pair_sum(cr, ct));
		acc = acc + 128'(rr*yy) * 128'(pair_sum(ca, cc) + pair_sum(ca, ct)
			+ pair_sum(cg, cc) + pair_sum(cg, ct));
		acc = acc + (128'sd1 <<< 23);
		sh = acc >>> FRAC_SH;
		if (sh[127:63] != {65{sh[127]}})
			return sh[127] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
		return sh[63:0];
	endfunction

	function automatic void apply_update(int s, int b, logic signed [GRP_W-1:0] fg,
		logic signed [GRP_W-1:0] tg);
		if (b > 3)
			return;
		if (fg >= 0 && fg <= 2 && site_counts[s*NUM_CNT + fg*4 + b] > 0)
			site_counts[s*NUM_CNT + fg*4 + b]--;
		if (tg >= 0 && tg <= 2 && site_counts[s*NUM_CNT + tg*4 + b] < MAX_TAXA_DEF)
			site_counts[s*NUM_CNT + tg*4 + b]++;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(stim_t it);
		int g;
		score_exp_t e;
		func       <= it.fn;
		site       <= it.st;
		base       <= it.bs;
		from_group <= it.fg;
		to_group   <= it.tg;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (it.fn == FUNC_SCORE) begin
			e.st = it.st;
			e.sc = it.typed ? it.sc : site_score(it.st);
			pending_scores = {pending_scores, e};
			n_scores++;
		end else begin
			apply_update(it.st, it.bs, it.fg, it.tg);
			n_updates++;
		end
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_freqs(logic [FREQ_W-1:0] fa, logic [FREQ_W-1:0] fc,
		logic [FREQ_W-1:0] fgu, logic [FREQ_W-1:0] ft);
		logic [FREQ_W-1:0] vals [NUM_FREQ];
		vals = '{fa, fc, fgu, ft};
		wait_idle();
		for (int i = 0; i < NUM_FREQ; i++) begin
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= vals[i];
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			freq_q16[i] = vals[i];
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic stim_t rand_item();
		stim_t it;
		int r;
		it.typed = 0;
		it.sc = '0;
		it.fn = ($urandom_range(0, 9) == 0) ? FUNC_SCORE : FUNC_UPDATE;
		it.st = ($urandom_range(0, 9) < 8) ? SITE_W'(hot_sites[$urandom_range(0, 7)])
			: SITE_W'($urandom_range(0, 1023));
		it.bs = ($urandom_range(0, 9) == 0) ? BASE_W'($urandom_range(4, 15))
			: BASE_W'($urandom_range(0, 3));
		r = $urandom_range(0, 9);
		if (r < 5)
			it.fg = -3'sd1;
		else if (r < 9)
			it.fg = GRP_W'($urandom_range(0, 2));
		else
			it.fg = GRP_W'($urandom_range(0, 7));
		r = $urandom_range(0, 9);
		if (r < 9)
			it.tg = GRP_W'($urandom_range(0, 2));
		else
			it.tg = GRP_W'($urandom_range(0, 7));
		return it;
	endfunction

	task automatic run_random(int n);
		for (int i = 0; i < n; i++)
			send_item(rand_item());
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_scores.size() == 0) begin
					$error("score transfer with nothing expected: score=%0d site=%0d",
						score, score_site);
					errs++;
				end else begin
					score_exp_t e;
					e = pending_scores.pop_front();
					n_checked++;
					if (score !== e.sc) begin
						$error("score: expected %0d, got %0d", e.sc, score);
						errs++;
					end
					if (score_site !== e.st) begin
						$error("score_site: expected %0d, got %0d", e.st, score_site);
						errs++;
					end
				end
			end
			if (hold_long) begin
				hold_long = 0;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				out_stall <= 1'b0;
			end else if (no_idle) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= (pick_gap() > 0);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("watchdog: no transfer for %0d cycles", idle_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		stim_t directed [$];
		stim_t it;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_UPDATE;
		site = '0;
		base = '0;
		from_group = '0;
		to_group = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errs = 0;
		n_updates = 0;
		n_scores = 0;
		n_checked = 0;
		idle_cycles = 0;
		no_idle = 0;
		hold_long = 0;
		foreach (site_counts[i])
			site_counts[i] = 0;
		freq_q16 = '{FREQ_A_RST, FREQ_C_RST, FREQ_G_RST, FREQ_T_RST};
		for (int i = 0; i < 8; i++)
			hot_sites[i] = $urandom_range(0, 1023);

		directed = '{
			'{FUNC_SCORE,  10'd0,    4'd0,  -3'sd1, -3'sd1, 1, 64'sd0},
			'{FUNC_SCORE,  10'd1023, 4'd0,  -3'sd1, -3'sd1, 1, 64'sd0},
			'{FUNC_UPDATE, 10'd5,    4'd0,  -3'sd1,  3'sd0, 0, 64'sd0},
			'{FUNC_UPDATE, 10'd5,    4'd0,  -3'sd1,  3'sd0, 0, 64'sd0},
			'{FUNC_UPDATE, 10'd5,    4'd1,  -3'sd1,  3'sd1, 0, 64'sd0},
			'{FUNC_UPDATE, 10'd5,    4'd1,  -3'sd1,  3'sd1, 0, 64'sd0},
			'{FUNC_UPDATE, 10'd5,    4'd2,  -3'sd1,  3'sd2, 0, 64'sd0},
			'{FUNC_UPDATE, 10'd5,    4'd3,  -3'sd1,  3'sd2, 0, 64'sd0},
			'{FUNC_UPDATE, 10'd5,    4'd3,  -3'sd1,  3'sd0, 0, 64'sd0},
			'{FUNC_UPDATE, 10'd5,    4'd2,  -3'sd1,  3'sd1, 0, 64'sd0},
			'{FUNC_SCORE,  10'd5,    4'd0,  -3'sd1, -3'sd1, 0, 64'sd0},
			'{FUNC_UPDATE, 10'd5,    4'd15, -3'sd1,  3'sd0, 0, 64'sd0},
			'{FUNC_UPDATE, 10'd5,    4'd4,   3'sd0,  3'sd1, 0, 64'sd0},
			'{FUNC_UPDATE, 10'd5,    4'd0,   3'sd3, -3'sd4, 0, 64'sd0},
			'{FUNC_UPDATE, 10'd5,    4'd0,  -3'sd2, -3'sd3, 0, 64'sd0},
			'{FUNC_UPDATE, 10'd5,    4'd1,   3'sd1,  3'sd1, 0, 64'sd0},
			'{FUNC_UPDATE, 10'd5,    4'd2,   3'sd0,  3'sd0, 0, 64'sd0},
			'{FUNC_UPDATE, 10'd5,    4'd3,   3'sd2, -3'sd1, 0, 64'sd0},
			'{FUNC_UPDATE, 10'd5,    4'd0,   3'sd0,  3'sd2, 0, 64'sd0},
			'{FUNC_UPDATE, 10'd1023, 4'd3,   3'sd1,  3'sd2, 0, 64'sd0},
			'{FUNC_SCORE,  10'd1023, 4'd0,  -3'sd1, -3'sd1, 0, 64'sd0},
			'{FUNC_SCORE,  10'd5,    4'd0,  -3'sd1, -3'sd1, 0, 64'sd0},
			'{FUNC_SCORE,  10'd700,  4'd0,  -3'sd1, -3'sd1, 1, 64'sd0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_item(directed[i]);
		run_random(200);

		// full-scale frequencies, then drive one counter into its ceiling
		write_freqs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		no_idle = 1;
		for (int i = 0; i < 262; i++) begin
			it = '{FUNC_UPDATE, 10'd77, BASE_W'(i < 258 ? 1 : 2), -3'sd1,
				GRP_W'(i < 258 ? 0 : 1 + i % 2), 0, 64'sd0};
			send_item(it);
		end
		send_item('{FUNC_SCORE, 10'd77, 4'd0, -3'sd1, -3'sd1, 0, 64'sd0});
		send_item('{FUNC_UPDATE, 10'd77, 4'd1, 3'sd0, -3'sd1, 0, 64'sd0});
		send_item('{FUNC_SCORE, 10'd77, 4'd0, -3'sd1, -3'sd1, 0, 64'sd0});
		no_idle = 0;
		run_random(150);

		write_freqs(16'h0000, 16'h0000, 16'h0000, 16'h0000);
		run_random(150);

		write_freqs(16'h0001, 16'hFFFF, 16'h0000, 16'h8000);
		hold_long = 1;
		run_random(200);

		write_freqs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		no_idle = 1;
		run_random(150);
		no_idle = 0;
		run_random(150);

		wait_idle();
		repeat (40) @(posedge clk);
		$display("covered %0d updates and %0d scores over 5 frequency settings",
			n_updates, n_scores);
		$display("%0d scores checked, %0d mismatches", n_checked, errs);
		if (errs == 0 && pending_scores.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
